### src/satoc_pkg.sv
// Shared types and constants for the set-associative take-out cache.
package satoc_pkg;

  // Geometry
  localparam int NUM_SETS = 64;
  localparam int WAYS     = 4;
  localparam int SET_W    = (NUM_SETS > 1) ? $clog2(NUM_SETS) : 1;
  localparam int WAY_W    = (WAYS > 1) ? $clog2(WAYS) : 1;

  // Victim LFSR
  localparam logic [15:0] LFSR_SEED = 16'hACE1;
  localparam logic [15:0] LFSR_MASK = 16'hB400;

  // Request kinds
  localparam logic REQ_TAKE = 1'b0;
  localparam logic REQ_ADD  = 1'b1;

  typedef struct packed {
    logic        req_type;
    logic [31:0] hash_id;
    logic [15:0] handle;
  } satoc_req_t;

  typedef struct packed {
    logic        found;
    logic [15:0] found_handle;
    logic        evicted;
    logic [15:0] evicted_handle;
  } satoc_rsp_t;

  // One stored way and one whole set row
  typedef struct packed {
    logic [31:0] hash_id;
    logic [15:0] handle;
  } satoc_way_t;

  typedef satoc_way_t [WAYS-1:0] satoc_row_t;

  // Controller to datapath commands
  typedef struct packed {
    logic load;
    logic exec;
  } satoc_cmd_t;

  typedef enum logic {
    ST_IDLE,
    ST_EXEC
  } satoc_state_e;

endpackage

### src/satoc_ctrl.sv
// Controller state machine: sequences row read and update of one request.
module satoc_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start,
  output logic                busy,
  output satoc_pkg::satoc_cmd_t cmd_o
);
  import satoc_pkg::*;

  satoc_state_e state_q, state_d;

  // Advance state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (start) begin
          state_d = ST_EXEC;
        end
      end
      ST_EXEC: begin
        state_d = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // Drive commands
  always_comb begin
    cmd_o.load = 1'b0;
    cmd_o.exec = 1'b0;
    busy       = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        cmd_o.load = start;
      end
      ST_EXEC: begin
        cmd_o.exec = 1'b1;
        busy       = 1'b1;
      end
      default: begin
        cmd_o.load = 1'b0;
      end
    endcase
  end

endmodule

### src/satoc_dpath.sv
// Datapath: set memory, valid bits, way compare, victim LFSR and result register.
module satoc_dpath (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  satoc_pkg::satoc_cmd_t cmd_i,
  input  satoc_pkg::satoc_req_t req_i,
  output logic                  done_o,
  output satoc_pkg::satoc_rsp_t rsp_o
);
  import satoc_pkg::*;

  satoc_row_t            mem_q [NUM_SETS];
  logic [WAYS-1:0]       valid_q [NUM_SETS];
  satoc_row_t            rd_q;
  logic [WAYS-1:0]       vrow_q;
  satoc_req_t            req_q;
  logic [SET_W-1:0]      set_q;
  logic [15:0]           lfsr_q, lfsr_d;
  logic                  done_q;
  satoc_rsp_t            rsp_q, rsp_d;

  logic [SET_W-1:0]      in_set;
  logic [WAYS-1:0]       vrow;
  logic                  hit_any, empty_any;
  logic [WAY_W-1:0]      hit_idx, empty_idx, victim_idx, tgt_idx;
  satoc_row_t            wr_row;
  logic                  wr_en;
  logic [WAYS-1:0]       valid_d;

  // Set of the incoming request
  assign in_set = SET_W'(req_i.hash_id % NUM_SETS);

  // Read the set row and its valid bits, and hold the request
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      rd_q   <= mem_q[in_set];
      vrow_q <= valid_q[in_set];
      req_q  <= req_i;
      set_q  <= in_set;
    end
  end

  // Scan the ways of the held row
  assign vrow       = vrow_q;
  assign victim_idx = WAY_W'(lfsr_q % WAYS);

  always_comb begin
    hit_any   = 1'b0;
    hit_idx   = '0;
    empty_any = 1'b0;
    empty_idx = '0;
    for (int w = 0; w < WAYS; w++) begin
      if (!hit_any && vrow[w] && (rd_q[w].hash_id == req_q.hash_id)) begin
        hit_any = 1'b1;
        hit_idx = WAY_W'(w);
      end
      if (!empty_any && !vrow[w]) begin
        empty_any = 1'b1;
        empty_idx = WAY_W'(w);
      end
    end
  end

  // Build the update and the result
  always_comb begin
    tgt_idx = empty_any ? empty_idx : victim_idx;
    wr_row  = rd_q;
    valid_d = vrow;
    wr_en   = 1'b0;
    rsp_d   = '0;
    if (req_q.req_type == REQ_ADD) begin
      wr_en                   = cmd_i.exec;
      wr_row[tgt_idx].hash_id = req_q.hash_id;
      wr_row[tgt_idx].handle  = req_q.handle;
      valid_d[tgt_idx]        = 1'b1;
      rsp_d.evicted           = !empty_any;
      rsp_d.evicted_handle    = empty_any ? 16'h0000 : rd_q[tgt_idx].handle;
    end else begin
      if (hit_any) begin
        valid_d[hit_idx]   = 1'b0;
        rsp_d.found        = 1'b1;
        rsp_d.found_handle = rd_q[hit_idx].handle;
      end
    end
  end

  // Write back the row on add
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_q[set_q] <= wr_row;
    end
  end

  // Update valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int s = 0; s < NUM_SETS; s++) begin
        valid_q[s] <= '0;
      end
    end else if (cmd_i.exec) begin
      valid_q[set_q] <= valid_d;
    end
  end

  // Step the LFSR once per request
  assign lfsr_d = lfsr_q[0] ? ((lfsr_q >> 1) ^ LFSR_MASK) : (lfsr_q >> 1);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lfsr_q <= LFSR_SEED;
      done_q <= 1'b0;
    end else begin
      done_q <= cmd_i.exec;
      if (cmd_i.exec) begin
        lfsr_q <= lfsr_d;
      end
    end
  end

  // Hold the result
  always_ff @(posedge clk_i) begin
    if (cmd_i.exec) begin
      rsp_q <= rsp_d;
    end
  end

  assign done_o = done_q;
  assign rsp_o  = rsp_q;

endmodule

### src/set_assoc_take_out_cache.sv
// Top level of the set-associative take-out cache.
// A request is taken when start is high and busy is low. The set row is read
// at that edge, busy is high for the next cycle while the ways are compared
// and the row is written back, and the result appears on rsp_o with done_o
// high for exactly one cycle after that.
// The receiver cannot stall; a new request may be issued in the same cycle
// as the previous result. A new request is not taken while busy, because of
// the read-modify-write of the single set memory. Valid bits clear at
// reset, so no clearing pass is needed.
module set_assoc_take_out_cache (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  start,
  output logic                  busy,
  input  satoc_pkg::satoc_req_t req_i,
  output logic                  done_o,
  output satoc_pkg::satoc_rsp_t rsp_o
);
  import satoc_pkg::*;

  satoc_cmd_t cmd;

  satoc_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start  (start),
    .busy   (busy),
    .cmd_o  (cmd)
  );

  satoc_dpath u_dpath (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cmd_i  (cmd),
    .req_i  (req_i),
    .done_o (done_o),
    .rsp_o  (rsp_o)
  );

endmodule

### src/satoc_chk.sv
// Port-level checker for the take-out cache, bound to the top level.
module satoc_chk (
  input logic                  clk_i,
  input logic                  rst_ni,
  input logic                  start,
  input logic                  busy,
  input satoc_pkg::satoc_req_t req_i,
  input logic                  done_o,
  input satoc_pkg::satoc_rsp_t rsp_o
);
  import satoc_pkg::*;

  // Accepted request keeps the block busy for one cycle
  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> busy)
    else $error("request accepted but block not busy");

  // Busy cycle ends with a result strobe
  a_busy_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy |=> (done_o && !busy))
    else $error("busy cycle not followed by result");

  // Result only in the cycle after a busy cycle
  a_done_src: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(busy))
    else $error("result without a request in flight");

  // A take hit and an eviction never come together
  a_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> !(rsp_o.found && rsp_o.evicted))
    else $error("found and evicted both set");

  // Handles are zero when their flag is clear
  a_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> ((rsp_o.found || rsp_o.found_handle == 16'h0000) &&
                (rsp_o.evicted || rsp_o.evicted_handle == 16'h0000)))
    else $error("nonzero handle without flag");

endmodule

bind set_assoc_take_out_cache satoc_chk u_satoc_chk (.*);

### tb/satoc_checker.sv
// Response checker for the set-associative take-out cache: shadow model plus compare.
`timescale 1ns / 1ps
module satoc_checker (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  start_i,
  input  logic                  busy_i,
  input  satoc_pkg::satoc_req_t req_i,
  input  logic                  done_i,
  input  satoc_pkg::satoc_rsp_t rsp_i,
  output int                    mismatch_cnt_o,
  output int                    pending_o
);
  import satoc_pkg::*;

  localparam int SLOTS = NUM_SETS * WAYS;

  // Shadow copy of the cache contents and the victim LFSR
  logic        shadow_valid  [SLOTS];
  logic [31:0] shadow_hash   [SLOTS];
  logic [15:0] shadow_handle [SLOTS];
  logic [15:0] victim_lfsr;

  satoc_rsp_t  rsp_due_q [$];
  satoc_rsp_t  rsp_due;
  int          mismatches;

  // Apply one request to the shadow cache and return the response it must produce
  function automatic satoc_rsp_t apply_request(satoc_req_t r);
    int         base;
    int         slot;
    bit         placed;
    satoc_rsp_t rsp;
    rsp    = '0;
    placed = 1'b0;
    base   = int'(r.hash_id % NUM_SETS) * WAYS;
    if (r.req_type == REQ_TAKE) begin
      // Remove the lowest-numbered valid way holding this hash
      for (int w = 0; w < WAYS; w++) begin
        slot = base + w;
        if (!rsp.found && shadow_valid[slot] && shadow_hash[slot] == r.hash_id) begin
          rsp.found         = 1'b1;
          rsp.found_handle  = shadow_handle[slot];
          shadow_valid[slot] = 1'b0;
        end
      end
    end else begin
      // Fill the first empty way, duplicates allowed
      for (int w = 0; w < WAYS; w++) begin
        slot = base + w;
        if (!placed && !shadow_valid[slot]) begin
          shadow_valid[slot]  = 1'b1;
          shadow_hash[slot]   = r.hash_id;
          shadow_handle[slot] = r.handle;
          placed = 1'b1;
        end
      end
      // Full set: replace the way picked by the LFSR value before it steps
      if (!placed) begin
        slot = base + int'(victim_lfsr % WAYS);
        rsp.evicted         = 1'b1;
        rsp.evicted_handle  = shadow_handle[slot];
        shadow_hash[slot]   = r.hash_id;
        shadow_handle[slot] = r.handle;
      end
    end
    // Step the Galois LFSR on every request
    victim_lfsr = {1'b0, victim_lfsr[15:1]} ^ (victim_lfsr[0] ? LFSR_MASK : 16'h0000);
    return rsp;
  endfunction

  // Retire responses first, then queue the prediction for a newly taken request
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int s = 0; s < SLOTS; s++) begin
        shadow_valid[s] = 1'b0;
      end
      victim_lfsr = LFSR_SEED;
      rsp_due_q.delete();
      mismatches = 0;
      pending_o      <= 0;
      mismatch_cnt_o <= 0;
    end else begin
      if (done_i) begin
        if (rsp_due_q.size() == 0) begin
          $error("response with no request outstanding: %h", rsp_i);
          mismatches++;
        end else begin
          rsp_due = rsp_due_q.pop_front();
          if (rsp_i.found !== rsp_due.found) begin
            $error("found: expected %0d, actual %0d", rsp_due.found, rsp_i.found);
            mismatches++;
          end
          if (rsp_i.found_handle !== rsp_due.found_handle) begin
            $error("found_handle: expected %h, actual %h",
                   rsp_due.found_handle, rsp_i.found_handle);
            mismatches++;
          end
          if (rsp_i.evicted !== rsp_due.evicted) begin
            $error("evicted: expected %0d, actual %0d", rsp_due.evicted, rsp_i.evicted);
            mismatches++;
          end
          if (rsp_i.evicted_handle !== rsp_due.evicted_handle) begin
            $error("evicted_handle: expected %h, actual %h",
                   rsp_due.evicted_handle, rsp_i.evicted_handle);
            mismatches++;
          end
        end
      end
      if (start_i && !busy_i) begin
        rsp_due_q.push_back(apply_request(req_i));
      end
      pending_o      <= rsp_due_q.size();
      mismatch_cnt_o <= mismatches;
    end
  end

endmodule

### tb/tb_set_assoc_take_out_cache.sv
// Top of the take-out cache testbench: clock, reset, request stimulus and verdict.
`timescale 1ns / 1ps
module tb_set_assoc_take_out_cache;
  import satoc_pkg::*;

  localparam int IDLE_LIMIT   = 1000;
  localparam int RANDOM_ITEMS = 400;
  localparam int KEY_POOL_MAX = 24;

  logic       clk_i = 1'b0;
  logic       rst_ni;
  logic       start;
  logic       busy;
  satoc_req_t req_i;
  logic       done_o;
  satoc_rsp_t rsp_o;

  int          mismatch_cnt;
  int          pending_cnt;
  int          idle_pct;
  int          stall_cycles = 0;
  logic [31:0] added_keys [$];

  always #5 clk_i = ~clk_i;

  set_assoc_take_out_cache i_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start  (start),
    .busy   (busy),
    .req_i  (req_i),
    .done_o (done_o),
    .rsp_o  (rsp_o)
  );

  satoc_checker i_checker (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start_i        (start),
    .busy_i         (busy),
    .req_i          (req_i),
    .done_i         (done_o),
    .rsp_i          (rsp_o),
    .mismatch_cnt_o (mismatch_cnt),
    .pending_o      (pending_cnt)
  );

  // Abort when neither a request nor a response moves for too long
  always @(posedge clk_i) begin
    if ((start && !busy) || done_o) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= IDLE_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  // Drive one request, idling at random first, and hold it until taken
  task automatic issue_request(input logic kind, input logic [31:0] key,
                               input logic [15:0] hnd);
    satoc_req_t r;
    bit         waiting;
    r.req_type = kind;
    r.hash_id  = key;
    r.handle   = hnd;
    waiting    = 1'b1;
    while (waiting) begin
      @(negedge clk_i);
      if ($urandom_range(99) < idle_pct) begin
        start <= 1'b0;
      end else begin
        start   <= 1'b1;
        req_i   <= r;
        waiting = 1'b0;
      end
    end
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
    // Remember added keys so later takes can hit them
    if (kind == REQ_ADD) begin
      added_keys.push_back(key);
      if (added_keys.size() > KEY_POOL_MAX) void'(added_keys.pop_front());
    end
  endtask

  // Mostly crowd a few hot sets so they fill up and evict
  function automatic logic [31:0] pick_key();
    logic [31:0] key;
    int unsigned roll;
    roll = $urandom_range(99);
    key  = $urandom;
    if (roll < 70) begin
      key[SET_W-1:0] = SET_W'($urandom_range(3));
    end else if (roll < 80) begin
      key[SET_W-1:0] = SET_W'(NUM_SETS - 1);
    end
    return key;
  endfunction

  function automatic logic [15:0] pick_handle();
    int unsigned roll;
    roll = $urandom_range(99);
    if (roll < 5) return 16'h0000;
    if (roll < 10) return 16'hFFFF;
    return 16'($urandom_range(16'hFFFF));
  endfunction

  initial begin
    rst_ni   = 1'b0;
    start    = 1'b0;
    req_i    = '0;
    idle_pct = 19;
    repeat (3) @(negedge clk_i);
    rst_ni <= 1'b1;

    // Miss on an empty cache, then key and handle extremes
    issue_request(REQ_TAKE, 32'h0000_0000, 16'hFFFF);
    issue_request(REQ_ADD,  32'h0000_0000, 16'h0000);
    issue_request(REQ_ADD,  32'hFFFF_FFFF, 16'hFFFF);
    issue_request(REQ_TAKE, 32'hFFFF_FFFF, 16'h0000);
    issue_request(REQ_TAKE, 32'hFFFF_FFFF, 16'h1234);
    // Duplicate adds in set 0, fill it, then force evictions
    issue_request(REQ_ADD,  32'h0000_0040, 16'h1111);
    issue_request(REQ_ADD,  32'h0000_0040, 16'h2222);
    issue_request(REQ_ADD,  32'h0000_0080, 16'h3333);
    issue_request(REQ_ADD,  32'h0000_00C0, 16'h4444);
    issue_request(REQ_ADD,  32'h0000_0100, 16'h5555);
    issue_request(REQ_ADD,  32'h8000_0000, 16'h6666);
    // Lowest matching way goes first; same set, other key misses
    issue_request(REQ_TAKE, 32'h0000_0040, 16'h0000);
    issue_request(REQ_TAKE, 32'h0000_0040, 16'h0000);
    issue_request(REQ_TAKE, 32'h1000_0000, 16'h0000);
    issue_request(REQ_TAKE, 32'h0000_0000, 16'h0000);
    // Fill the top set and overflow it
    issue_request(REQ_ADD,  32'h0000_003F, 16'hA001);
    issue_request(REQ_ADD,  32'h0000_007F, 16'hA002);
    issue_request(REQ_ADD,  32'h0000_00BF, 16'hA003);
    issue_request(REQ_ADD,  32'hFFFF_FFFF, 16'hA004);
    issue_request(REQ_ADD,  32'h7FFF_FFFF, 16'hA005);
    issue_request(REQ_TAKE, 32'hFFFF_FFFF, 16'h0000);
    issue_request(REQ_TAKE, 32'h0000_003F, 16'h0000);

    // Random mix of adds and takes, with a stretch of back-to-back requests
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      idle_pct = (n >= 150 && n < 250) ? 0 : 19;
      if ($urandom_range(99) < 55) begin
        issue_request(REQ_ADD, pick_key(), pick_handle());
      end else if (added_keys.size() > 0 && $urandom_range(99) < 70) begin
        issue_request(REQ_TAKE, added_keys[$urandom_range(added_keys.size() - 1)],
                      pick_handle());
      end else begin
        issue_request(REQ_TAKE, pick_key(), pick_handle());
      end
    end

    // Drain outstanding responses, then let the pipeline settle
    @(negedge clk_i);
    start <= 1'b0;
    while (pending_cnt != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
    if (mismatch_cnt == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
